@@ rtl/rat_acc_pkg.sv @@
// Package: shared types, codes and widths for the rational accumulator ALU.
`timescale 1ns / 1ps
package rat_acc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAG_W = 64;

	typedef enum logic [2:0] {
		REQ_LOAD = 3'd0,
		REQ_ADD  = 3'd1,
		REQ_SUB  = 3'd2,
		REQ_MUL  = 3'd3,
		REQ_DIV  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] acc_num;
		logic [30:0]        acc_den;
		logic [1:0]         status;
	} out_item_t;

	// Shared unit operations.
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} uop_t;

	typedef struct packed {
		logic       start;
		uop_t       op;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic       done;
		logic [MAG_W-1:0] quo;
		logic [MAG_W-1:0] rem;
	} unit_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_OPG_START,
		S_OPG_WAIT,
		S_OPR_START,
		S_OPR_WAIT,
		S_OPR2_START,
		S_OPR2_WAIT,
		S_M1_START,
		S_M1_WAIT,
		S_M2_START,
		S_M2_WAIT,
		S_M3_START,
		S_M3_WAIT,
		S_COMBINE,
		S_RG_START,
		S_RG_WAIT,
		S_RR_START,
		S_RR_WAIT,
		S_RR2_START,
		S_RR2_WAIT,
		S_FINISH,
		S_OUT
	} state_t;

endpackage

@@ rtl/rat_acc_unit.sv @@
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module rat_acc_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rat_acc_pkg::unit_req_t req,
	output rat_acc_pkg::unit_rsp_t rsp
);
	import rat_acc_pkg::*;

	logic             busy_q;
	uop_t             op_q;
	logic [6:0]       cnt_q;
	logic [MAG_W-1:0] acc_q;
	logic [MAG_W-1:0] x_q;
	logic [MAG_W-1:0] y_q;
	logic             done_q;
	logic [MAG_W:0]   trial;
	logic [MAG_W-1:0] rem_sh;

	// One restoring step on the partial remainder.
	always_comb begin
		rem_sh = {acc_q[MAG_W-2:0], x_q[MAG_W-1]};
		trial = {1'b0, rem_sh} - {1'b0, y_q};
	end

	// Sequencing: 64 steps per operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: acc is product or remainder, x is multiplier or quotient.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.a;
			y_q   <= req.b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= x_q[0] ? acc_q + (y_q << cnt_q[5:0]) : acc_q;
				x_q   <= x_q >> 1;
			end else if (!trial[MAG_W]) begin
				acc_q <= trial[MAG_W-1:0];
				x_q   <= {x_q[MAG_W-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh;
				x_q   <= {x_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = (op_q == OP_MUL) ? acc_q : x_q;
		rsp.rem  = acc_q;
	end
endmodule

@@ rtl/rat_acc_seq.sv @@
// Sequencer: normalises operands, drives the shared unit, runs gcd reduction.
`timescale 1ns / 1ps
module rat_acc_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  rat_acc_pkg::in_item_t  in_item,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rat_acc_pkg::out_item_t out_item,
	output rat_acc_pkg::unit_req_t ureq,
	input  rat_acc_pkg::unit_rsp_t ursp
);
	import rat_acc_pkg::*;

	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (VALUE_WIDTH - 1);

	state_t state_q, state_d;

	logic [2:0]       req_q;
	logic             opneg_q;
	logic [MAG_W-1:0] opmag_q, opden_q;
	logic             accneg_q;
	logic [MAG_W-1:0] accmag_q, accden_q;
	logic             resneg_q;
	logic [MAG_W-1:0] resmag_q, resden_q;
	logic [MAG_W-1:0] t1_q, t2_q;
	// Euclid working pair and saved gcd.
	logic [MAG_W-1:0] gx_q, gy_q, g_q;
	logic [1:0]       status_q;
	logic signed [31:0] out_num_q;
	logic [30:0]      out_den_q;
	logic [1:0]       out_st_q;

	logic             nneg, dneg;
	logic [MAG_W-1:0] nmag, dmag;
	logic             is_addsub, bneg;
	logic             fits;
	logic signed [VALUE_WIDTH-1:0] acc_stored;

	// Split operand fields into sign and magnitude.
	always_comb begin
		nneg = in_item.operand_num[31];
		dneg = in_item.operand_den[31];
		nmag = nneg ? MAG_W'(33'h1_0000_0000 - {1'b0, in_item.operand_num})
			: MAG_W'(in_item.operand_num);
		dmag = dneg ? MAG_W'(33'h1_0000_0000 - {1'b0, in_item.operand_den})
			: MAG_W'(in_item.operand_den);
		is_addsub = (req_q == REQ_ADD) || (req_q == REQ_SUB);
		bneg      = (req_q == REQ_SUB) ? !opneg_q : opneg_q;
		fits = (resden_q >= MAG_W'(1)) && (resden_q <= LIM - MAG_W'(1)) &&
			(resneg_q ? (resmag_q <= LIM) : (resmag_q <= LIM - MAG_W'(1)));
		acc_stored = resneg_q ? VALUE_WIDTH'(~resmag_q + MAG_W'(1))
			: VALUE_WIDTH'(resmag_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (req_q > REQ_DIV) state_d = S_OUT;
				else if (opden_q == '0) state_d = S_OUT;
				else if (req_q == REQ_DIV && opmag_q == '0) state_d = S_OUT;
				else if (opmag_q == '0) state_d = S_M1_START;
				else state_d = S_OPG_START;
			end
			S_OPG_START:  state_d = S_OPG_WAIT;
			S_OPG_WAIT: begin
				if (ursp.done) state_d = (ursp.rem == '0) ? S_OPR_START : S_OPG_START;
			end
			S_OPR_START:  state_d = S_OPR_WAIT;
			S_OPR_WAIT:   if (ursp.done) state_d = S_OPR2_START;
			S_OPR2_START: state_d = S_OPR2_WAIT;
			S_OPR2_WAIT:  if (ursp.done) state_d = S_M1_START;
			S_M1_START: begin
				if (req_q == REQ_LOAD) state_d = S_RG_START;
				else state_d = S_M1_WAIT;
			end
			S_M1_WAIT:    if (ursp.done) state_d = S_M2_START;
			S_M2_START:   state_d = S_M2_WAIT;
			S_M2_WAIT:    if (ursp.done) state_d = is_addsub ? S_M3_START : S_COMBINE;
			S_M3_START:   state_d = S_M3_WAIT;
			S_M3_WAIT:    if (ursp.done) state_d = S_COMBINE;
			S_COMBINE:    state_d = S_RG_START;
			S_RG_START:   state_d = (resmag_q == '0) ? S_FINISH : S_RG_WAIT;
			S_RG_WAIT: begin
				if (ursp.done) state_d = (ursp.rem == '0) ? S_RR_START : S_RG_WAIT;
			end
			S_RR_START:   state_d = S_RR_WAIT;
			S_RR_WAIT:    if (ursp.done) state_d = S_RR2_START;
			S_RR2_START:  state_d = S_RR2_WAIT;
			S_RR2_WAIT:   if (ursp.done) state_d = S_FINISH;
			S_FINISH:     state_d = S_OUT;
			S_OUT:        if (!out_stall) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// Unit requests per state.
	always_comb begin
		ureq = '0;
		ureq.op = OP_DIV;
		case (state_q)
			S_OPG_START: begin
				ureq.start = 1'b1; ureq.a = gx_q; ureq.b = gy_q;
			end
			S_OPR_START: begin
				ureq.start = 1'b1; ureq.a = opmag_q; ureq.b = g_q;
			end
			S_OPR2_START: begin
				ureq.start = 1'b1; ureq.a = opden_q; ureq.b = g_q;
			end
			S_M1_START: begin
				ureq.start = (req_q != REQ_LOAD); ureq.op = OP_MUL;
				ureq.a = accmag_q;
				ureq.b = is_addsub ? opden_q : ((req_q == REQ_DIV) ? opden_q : opmag_q);
			end
			S_M2_START: begin
				ureq.start = 1'b1; ureq.op = OP_MUL; ureq.a = accden_q;
				ureq.b = is_addsub ? opmag_q : ((req_q == REQ_DIV) ? opmag_q : opden_q);
			end
			S_M3_START: begin
				ureq.start = 1'b1; ureq.op = OP_MUL; ureq.a = accden_q; ureq.b = opden_q;
			end
			S_RG_START: begin
				ureq.start = (resmag_q != '0); ureq.a = resmag_q; ureq.b = resden_q;
			end
			S_RG_WAIT: begin
				ureq.start = ursp.done && (ursp.rem != '0);
				ureq.a = gy_q; ureq.b = ursp.rem;
			end
			S_RR_START: begin
				ureq.start = 1'b1; ureq.a = resmag_q; ureq.b = g_q;
			end
			S_RR2_START: begin
				ureq.start = 1'b1; ureq.a = resden_q; ureq.b = g_q;
			end
			default: ureq.start = 1'b0;
		endcase
	end

	always_comb begin
		in_stall           = (state_q != S_IDLE);
		out_valid          = (state_q == S_OUT);
		out_item.acc_num   = out_num_q;
		out_item.acc_den   = out_den_q;
		out_item.status    = out_st_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			accneg_q <= 1'b0;
			accmag_q <= MAG_W'(1);
			accden_q <= MAG_W'(1);
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && status_q == ST_OK && fits) begin
				accneg_q <= resneg_q;
				accmag_q <= resmag_q;
				accden_q <= resden_q;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q    <= in_item.req_type;
				opmag_q  <= nmag;
				opden_q  <= dmag;
				opneg_q  <= (dneg && nmag != '0) ? !nneg : nneg;
				gx_q     <= nmag;
				gy_q     <= dmag;
				status_q <= ST_OK;
			end
			S_CHECK: begin
				if (req_q <= REQ_DIV && opden_q == '0) status_q <= ST_ZERO_DEN;
				else if (req_q == REQ_DIV && opmag_q == '0) status_q <= ST_DIV_ZERO;
				if (opmag_q == '0) begin
					opneg_q <= 1'b0;
					opden_q <= MAG_W'(1);
				end
				resneg_q <= 1'b0;
				resmag_q <= '0;
				resden_q <= MAG_W'(1);
			end
			S_OPG_WAIT: begin
				if (ursp.done) begin
					if (ursp.rem == '0) g_q <= gy_q;
					gx_q <= gy_q;
					gy_q <= ursp.rem;
				end
			end
			S_OPR_WAIT:  if (ursp.done) opmag_q <= ursp.quo;
			S_OPR2_WAIT: if (ursp.done) opden_q <= ursp.quo;
			S_M1_START: begin
				if (req_q == REQ_LOAD) begin
					resneg_q <= opneg_q;
					resmag_q <= opmag_q;
					resden_q <= opden_q;
					gy_q     <= opden_q;
				end
			end
			S_M1_WAIT:   if (ursp.done) t1_q <= ursp.quo;
			S_M2_WAIT:   if (ursp.done) t2_q <= ursp.quo;
			S_M3_WAIT:   if (ursp.done) resden_q <= ursp.quo;
			S_COMBINE: begin
				if (is_addsub) begin
					if (accneg_q == bneg) begin
						resmag_q <= t1_q + t2_q; resneg_q <= accneg_q;
					end else if (t1_q >= t2_q) begin
						resmag_q <= t1_q - t2_q; resneg_q <= accneg_q;
					end else begin
						resmag_q <= t2_q - t1_q; resneg_q <= bneg;
					end
				end else begin
					resmag_q <= t1_q;
					resden_q <= t2_q;
					resneg_q <= accneg_q != opneg_q;
				end
				gy_q <= is_addsub ? resden_q : t2_q;
			end
			S_RG_START: begin
				if (resmag_q == '0) begin
					resneg_q <= 1'b0;
					resden_q <= MAG_W'(1);
				end
				gy_q <= resden_q;
			end
			S_RG_WAIT: begin
				if (ursp.done) begin
					if (ursp.rem == '0) g_q <= gy_q;
					gy_q <= ursp.rem;
				end
			end
			S_RR_WAIT:   if (ursp.done) resmag_q <= ursp.quo;
			S_RR2_WAIT:  if (ursp.done) resden_q <= ursp.quo;
			S_FINISH: begin
				if (status_q == ST_OK && req_q <= REQ_DIV && fits) begin
					out_num_q <= 32'(acc_stored);
					out_den_q <= 31'(resden_q);
				end else begin
					out_num_q <= accneg_q ? 32'(~accmag_q + MAG_W'(1)) : 32'(accmag_q);
					out_den_q <= 31'(accden_q);
				end
				if (status_q == ST_OK && req_q <= REQ_DIV && !fits) out_st_q <= ST_OVERFLOW;
				else out_st_q <= status_q;
			end
			default: begin
				if (state_q == S_CHECK) out_st_q <= status_q;
			end
		endcase
		// Early exits from the check go straight to the result register.
		if (state_q == S_CHECK && state_d == S_OUT) begin
			out_num_q <= accneg_q ? 32'(~accmag_q + MAG_W'(1)) : 32'(accmag_q);
			out_den_q <= 31'(accden_q);
			if (req_q > REQ_DIV) out_st_q <= ST_OK;
			else if (opden_q == '0) out_st_q <= ST_ZERO_DEN;
			else out_st_q <= ST_DIV_ZERO;
		end
	end
endmodule

@@ rtl/rational_accumulator_alu.sv @@
// Top level of the rational accumulator ALU.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_item  (req_type, operand_num, operand_den)
//  output  | out_valid | out_stall | out_item (acc_num, acc_den, status)
//
// One item at a time. Each operation uses the shared 64-step multiply/divide unit for
// up to three products, plus each Euclid step and two divisions for each of the two
// reductions. A load of zero skips the unit: it passes from the check through the
// first multiply start, the gcd start and the finish state to the output. Rejected
// requests go from the check state straight to the output state.
// Reset clears the accumulator to 1/1. While a result waits under out_stall no new
// input is taken.
`timescale 1ns / 1ps
module rational_accumulator_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rat_acc_pkg::in_item_t  in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rat_acc_pkg::out_item_t out_item
);
	import rat_acc_pkg::*;

	unit_req_t ureq;
	unit_rsp_t ursp;

	rat_acc_seq u_seq (
		.clk, .arst_n, .in_valid, .in_item, .in_stall,
		.out_valid, .out_stall, .out_item, .ureq, .ursp
	);

	rat_acc_unit u_unit (.clk, .arst_n, .req(ureq), .rsp(ursp));
endmodule

@@ rtl/rat_acc_checker.sv @@
// Port checker for the rational accumulator ALU, bound to the top level.
`timescale 1ns / 1ps
module rat_acc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input rat_acc_pkg::out_item_t out_item
);
	import rat_acc_pkg::*;

	// A result is held while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed under stall");

	// No input is taken while a result is pending.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken with result pending");

	// The denominator shown is never zero.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.acc_den != '0)
		else $error("zero denominator shown");

	// An accepted item produces no result in the very next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");
endmodule

bind rational_accumulator_alu rat_acc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);

@@ tb/rational_accumulator_alu_test.sv @@
// Self-checking testbench for the rational accumulator ALU: directed and random operations.
`timescale 1ns / 1ps
module rational_accumulator_alu_test;
	import rat_acc_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd80000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	// Predicted accumulator state.
	logic signed [31:0] pred_num;
	logic [31:0] pred_den;

	out_item_t expected_results[$];
	int mismatch_count;
	longint cycle_count;

	rational_accumulator_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Works out the result of one transfer and advances the predicted accumulator.
	function automatic out_item_t predict_step(in_item_t it);
		out_item_t r;
		logic [1:0] st;
		logic op_neg, d_neg, acc_neg, b_neg, res_neg;
		logic [63:0] op_mag, op_den, acc_mag, acc_den, t1, t2, res_mag, res_den, g;
		logic [63:0] lim;
		st = ST_OK;
		op_neg = it.operand_num[31];
		op_mag = op_neg ? 64'h1_0000_0000 - {32'd0, it.operand_num} : {32'd0, it.operand_num};
		d_neg = it.operand_den[31];
		op_den = d_neg ? 64'h1_0000_0000 - {32'd0, it.operand_den} : {32'd0, it.operand_den};
		if (d_neg && op_mag != 0)
			op_neg = !op_neg;
		acc_neg = pred_num[31];
		acc_mag = acc_neg ? -64'(pred_num) : 64'(pred_num);
		acc_den = {32'd0, pred_den};
		if (it.req_type <= REQ_DIV) begin
			if (op_den == 0) begin
				st = ST_ZERO_DEN;
			end else if (it.req_type == REQ_DIV && op_mag == 0) begin
				st = ST_DIV_ZERO;
			end else begin
				if (op_mag == 0) begin
					op_neg = 1'b0;
					op_den = 1;
				end else begin
					g = euclid_gcd(op_mag, op_den);
					op_mag = op_mag / g;
					op_den = op_den / g;
				end
				case (it.req_type)
					REQ_LOAD: begin
						res_neg = op_neg;
						res_mag = op_mag;
						res_den = op_den;
					end
					REQ_ADD, REQ_SUB: begin
						b_neg = (it.req_type == REQ_SUB) ? !op_neg : op_neg;
						t1 = acc_mag * op_den;
						t2 = op_mag * acc_den;
						if (acc_neg == b_neg) begin
							res_mag = t1 + t2;
							res_neg = acc_neg;
						end else if (t1 >= t2) begin
							res_mag = t1 - t2;
							res_neg = acc_neg;
						end else begin
							res_mag = t2 - t1;
							res_neg = b_neg;
						end
						res_den = acc_den * op_den;
					end
					REQ_MUL: begin
						res_mag = acc_mag * op_mag;
						res_den = acc_den * op_den;
						res_neg = acc_neg != op_neg;
					end
					default: begin
						res_mag = acc_mag * op_den;
						res_den = acc_den * op_mag;
						res_neg = acc_neg != op_neg;
					end
				endcase
				if (res_mag == 0) begin
					res_neg = 1'b0;
					res_den = 1;
				end else begin
					g = euclid_gcd(res_mag, res_den);
					res_mag = res_mag / g;
					res_den = res_den / g;
				end
				lim = 64'd1 << (VALUE_WIDTH - 1);
				if (res_den < 1 || res_den > lim - 1 ||
					(res_neg ? res_mag > lim : res_mag > lim - 1)) begin
					st = ST_OVERFLOW;
				end else begin
					pred_num = res_neg ? -res_mag[31:0] : res_mag[31:0];
					pred_den = res_den[31:0];
				end
			end
		end
		r.acc_num = pred_num;
		r.acc_den = pred_den[30:0];
		r.status = st;
		return r;
	endfunction

	// Mostly short gaps, occasionally a long one.
	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 400);
	endfunction

	// Sends one item and records its predicted result once the transfer happens.
	task automatic send_item(logic [2:0] req, logic [31:0] num, logic [31:0] den);
		int gap;
		gap = random_gap();
		repeat (gap) @(negedge clk);
		in_item.req_type = req;
		in_item.operand_num = num;
		in_item.operand_den = den;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_step(in_item));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] random_value();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5)
			return 32'($signed($urandom_range(0, 40)) - 20);
		else if (p < 7)
			return 32'($signed($urandom_range(0, 2000)) - 1000);
		else if (p < 9)
			return $urandom;
		else
			return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	task automatic test_directed();
		send_item(REQ_LOAD, 32'h7fff_ffff, 32'd1);
		send_item(REQ_ADD, 32'd1, 32'd1);
		send_item(REQ_LOAD, 32'h8000_0000, 32'd1);
		send_item(REQ_SUB, 32'd1, 32'd1);
		send_item(REQ_LOAD, 32'd6, 32'hffff_fffc);
		send_item(REQ_ADD, 32'd1, 32'd2);
		send_item(REQ_SUB, 32'hffff_fffd, 32'd7);
		send_item(REQ_MUL, 32'd14, 32'hffff_fff7);
		send_item(REQ_DIV, 32'd3, 32'd5);
		send_item(REQ_DIV, 32'd0, 32'd5);
		send_item(REQ_ADD, 32'd3, 32'd0);
		send_item(REQ_LOAD, 32'd0, 32'hffff_ffff);
		send_item(REQ_MUL, 32'h7fff_ffff, 32'h8000_0000);
		send_item(REQ_LOAD, 32'd1, 32'h8000_0000);
		send_item(REQ_LOAD, 32'h8000_0000, 32'h8000_0000);
		send_item(REQ_DIV, 32'h8000_0000, 32'h7fff_ffff);
		send_item(3'd5, 32'd9, 32'd9);
		send_item(3'd6, 32'd0, 32'd0);
		send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff);
		send_item(REQ_LOAD, 32'h7fff_ffff, 32'h7fff_fffe);
		send_item(REQ_MUL, 32'h7fff_fffe, 32'h7fff_ffff);
		send_item(REQ_DIV, 32'h0000_0002, 32'h0000_0003);
	endtask

	task automatic test_random();
		int p;
		logic [31:0] den;
		for (int i = 0; i < 1530; i++) begin
			p = $urandom_range(0, 99);
			den = (p < 4) ? 32'd0 : random_value();
			if (den == 0 && p >= 4)
				den = 32'd1;
			if (p < 12)
				send_item(REQ_LOAD, random_value(), den);
			else if (p < 98)
				send_item(3'($urandom_range(1, 4)), random_value(), den);
			else
				send_item(3'($urandom_range(5, 7)), $urandom, $urandom);
		end
	endtask

	// Checks each result transfer against the oldest prediction.
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result transfer: %p", out_item);
			end else begin
				exp_item = expected_results.pop_front();
				if (out_item.acc_num !== exp_item.acc_num ||
					out_item.acc_den !== exp_item.acc_den ||
					out_item.status !== exp_item.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
							exp_item.acc_num, exp_item.acc_den, exp_item.status,
							out_item.acc_num, out_item.acc_den, out_item.status);
				end
			end
		end
	end

	// Random stall on the result side.
	always @(negedge clk) begin
		int p;
		p = $urandom_range(0, 99);
		if (cycle_count % 3000 < 600)
			out_stall <= 1'b0;
		else if (p < 2)
			out_stall <= 1'b1;
		else if (p < 35)
			out_stall <= $urandom_range(0, 1);
		else if (p < 60)
			out_stall <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		pred_num = 32'sd1;
		pred_den = 32'd1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		wait (expected_results.size() == 0);
		repeat (2500) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
